FILE: rtl/dolm_pkg.sv
// Shared types, constants and byte folding for the dictionary-order line matcher.
`timescale 1ns / 1ps
`default_nettype none

package dolm_pkg;

    localparam int MAX_KEY_DEF   = 64;
    localparam int LINE_BITS_DEF = 20;
    localparam int LINE_NUM_W    = 20;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_INDEX = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REL_BEFORE = 2'd0,
        REL_PREFIX = 2'd1,
        REL_EXACT  = 2'd2,
        REL_AFTER  = 2'd3
    } relation_t;

    typedef enum logic [1:0] {
        PH_COMPARE   = 2'd0,
        PH_DECIDED   = 2'd1,
        PH_AFTER_TAB = 2'd2
    } line_phase_t;

    typedef struct packed {
        relation_t               relation;
        logic                    matched;
        logic [LINE_NUM_W-1:0]   line_number;
        logic                    key_truncated;
        logic                    missing_tab;
    } result_t;

    // Bit 8 marks a significant byte (space, letter or digit); bits 7:0 hold
    // the byte with upper-case letters folded to lower case.
    function automatic logic [8:0] fold_byte(input logic [7:0] b);
        logic [8:0] r;
        begin
            r = {1'b0, b};
            if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
            begin
                r = {1'b1, b + CASE_SHIFT};
            end
            else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                     (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) || b == CH_SPACE)
            begin
                r = {1'b1, b};
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dolm_key_mem.sv
// Key store: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module dolm_key_mem
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] key_ram [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_ram[wr_addr] <= wr_data;
        end
    end

    // A write to the address being read lands in the read register directly,
    // so the compare never sees the old contents of that entry.
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr == rd_addr)
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= key_ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/dolm_line_ctrl.sv
// Key loading, headword compare and line bookkeeping around the key store.
`timescale 1ns / 1ps
`default_nettype none

module dolm_line_ctrl
    import dolm_pkg::*;
#(
    parameter int MAX_KEY   = MAX_KEY_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       accept,
    input  wire logic [1:0] command,
    input  wire logic [7:0] byte_value,
    output logic            res_valid,
    output result_t         res
);

    localparam int CW = $clog2(MAX_KEY + 1);
    localparam int AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

    logic [CW-1:0]        key_len_reg,   key_len_next;
    logic                 key_ovf_reg,   key_ovf_next;
    logic [CW-1:0]        match_pos_reg, match_pos_next;
    line_phase_t          phase_reg,     phase_next;
    relation_t            line_rel_reg,  line_rel_next;
    logic [LINE_BITS-1:0] line_cnt_reg,  line_cnt_next;
    logic                 match_mode_reg;

    logic [8:0]  fold;
    logic [7:0]  key_byte;
    logic        wr_en;
    relation_t   end_rel;
    relation_t   final_rel;

    assign fold = fold_byte(byte_value);

    dolm_key_mem
    #(
        .DEPTH (MAX_KEY),
        .AW    (AW)
    )
    u_key_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (key_len_reg[AW-1:0]),
        .wr_data (fold[7:0]),
        .rd_addr (match_pos_next[AW-1:0]),
        .rd_data (key_byte)
    );

    // Relation when the headword ends while still comparing.
    always_comb
    begin
        if (match_pos_reg < key_len_reg)
        begin
            end_rel = REL_AFTER;
        end
        else
        begin
            end_rel = REL_EXACT;
        end
    end

    always_comb
    begin
        if (phase_reg == PH_COMPARE)
        begin
            final_rel = end_rel;
        end
        else
        begin
            final_rel = line_rel_reg;
        end
    end

    always_comb
    begin
        key_len_next   = key_len_reg;
        key_ovf_next   = key_ovf_reg;
        match_pos_next = match_pos_reg;
        phase_next     = phase_reg;
        line_rel_next  = line_rel_reg;
        line_cnt_next  = line_cnt_reg;
        wr_en          = 1'b0;
        res_valid      = 1'b0;

        res.relation      = final_rel;
        res.matched       = (final_rel == REL_EXACT) ||
                            (match_mode_reg && final_rel == REL_PREFIX);
        res.line_number   = LINE_NUM_W'(line_cnt_reg);
        res.key_truncated = key_ovf_reg;
        res.missing_tab   = (phase_reg != PH_AFTER_TAB);

        if (accept)
        begin
            unique case (command)
                CMD_CLEAR:
                begin
                    key_len_next   = '0;
                    key_ovf_next   = 1'b0;
                    line_cnt_next  = '0;
                    match_pos_next = '0;
                    phase_next     = PH_COMPARE;
                    line_rel_next  = REL_BEFORE;
                end
                CMD_KEY:
                begin
                    if (fold[8])
                    begin
                        if (key_len_reg < CW'(MAX_KEY))
                        begin
                            wr_en        = 1'b1;
                            key_len_next = key_len_reg + CW'(1);
                        end
                        else
                        begin
                            key_ovf_next = 1'b1;
                        end
                    end
                end
                CMD_INDEX:
                begin
                    if (byte_value == CH_NEWLINE)
                    begin
                        res_valid      = 1'b1;
                        line_cnt_next  = line_cnt_reg + LINE_BITS'(1);
                        match_pos_next = '0;
                        phase_next     = PH_COMPARE;
                        line_rel_next  = REL_BEFORE;
                    end
                    else if (byte_value == CH_TAB)
                    begin
                        if (phase_reg == PH_COMPARE)
                        begin
                            line_rel_next = end_rel;
                        end
                        phase_next = PH_AFTER_TAB;
                    end
                    else if (phase_reg == PH_COMPARE && fold[8])
                    begin
                        // The key is used up but the headword goes on.
                        if (match_pos_reg >= key_len_reg)
                        begin
                            line_rel_next = REL_PREFIX;
                            phase_next    = PH_DECIDED;
                        end
                        else if (key_byte != fold[7:0])
                        begin
                            if (key_byte < fold[7:0])
                            begin
                                line_rel_next = REL_BEFORE;
                            end
                            else
                            begin
                                line_rel_next = REL_AFTER;
                            end
                            phase_next = PH_DECIDED;
                        end
                        else
                        begin
                            match_pos_next = match_pos_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg    <= '0;
            key_ovf_reg    <= 1'b0;
            match_pos_reg  <= '0;
            phase_reg      <= PH_COMPARE;
            line_rel_reg   <= REL_BEFORE;
            line_cnt_reg   <= '0;
            match_mode_reg <= 1'b0;
        end
        else
        begin
            key_len_reg   <= key_len_next;
            key_ovf_reg   <= key_ovf_next;
            match_pos_reg <= match_pos_next;
            phase_reg     <= phase_next;
            line_rel_reg  <= line_rel_next;
            line_cnt_reg  <= line_cnt_next;
            if (cfg_wr_en)
            begin
                match_mode_reg <= cfg_wr_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_within_key: assert property (@(posedge clk) disable iff (!rst_n)
        match_pos_reg <= key_len_reg)
        else $error("compare position ran past the key length");

    a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= CW'(MAX_KEY))
        else $error("key length exceeds the key store");

    a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_ovf_reg) |-> $past(key_len_reg) == CW'(MAX_KEY))
        else $error("key overflow flagged while the key store had room");
`endif

endmodule

`default_nettype wire

FILE: rtl/dolm_out_buf.sv
// Output register with a skid entry so the input side keeps moving under stall until that entry fills.
`timescale 1ns / 1ps
`default_nettype none

module dolm_out_buf
    import dolm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_stall
);

    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (slot_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("result pushed while the skid entry is occupied");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result ahead of an empty output");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && push))
        else $error("skid entry filled without a stalled output");
`endif

endmodule

`default_nettype wire

FILE: rtl/dictionary_order_line_matcher_core.sv
// Top level of the dictionary-order line matcher.
`timescale 1ns / 1ps
`default_nettype none

// Load a key with command 1 requests (clear it first with command 0), then
// stream index text with command 2 requests, one byte per request, lines of
// the form headword, tab, rest, newline. A new request, including a newline,
// is taken on every clock while item_stall is low. The key byte at the next
// compare position is fetched into the key store's read register as the
// position updates, with a write to that entry forwarded to the read, so
// each index byte is compared in the cycle it arrives. A newline's result is
// registered in the output register, or in a skid entry while the output is
// stalled, and item_stall rises only while that entry is occupied. There is no
// clearing pass after reset: only key entries written since the last clear
// are ever compared. match_mode may be written through cfg_wr_en and
// cfg_wr_data whenever the block is idle.
module dictionary_order_line_matcher_core
    import dolm_pkg::*;
#(
    parameter int MAX_KEY   = MAX_KEY_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [1:0]            command,
    input  wire logic [7:0]            byte_value,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [1:0]                 relation,
    output logic                       matched,
    output logic [LINE_NUM_W-1:0]      line_number,
    output logic                       key_truncated,
    output logic                       missing_tab
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    buf_full;

    assign item_stall = buf_full;
    assign accept     = item_valid && !buf_full;

    dolm_line_ctrl
    #(
        .MAX_KEY   (MAX_KEY),
        .LINE_BITS (LINE_BITS)
    )
    u_line_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .command     (command),
        .byte_value  (byte_value),
        .res_valid   (res_valid),
        .res         (res)
    );

    dolm_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_data  (out_data),
        .out_stall (result_stall)
    );

    assign relation      = out_data.relation;
    assign matched       = out_data.matched;
    assign line_number   = out_data.line_number;
    assign key_truncated = out_data.key_truncated;
    assign missing_tab   = out_data.missing_tab;

endmodule

`default_nettype wire
